FILE: hdl/idm_pkg.sv
`default_nettype none

package idm_pkg;

  // Width of the division datapath and of the fields on the ports
  localparam int DATA_W = 64;
  localparam int FIELD_W = 64;
  localparam int FUNC_W = 2;
  localparam int S_TDATA_W = 136;
  localparam int M_TDATA_W = 64;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_UDIV = 2'd0,
    FN_UREM = 2'd1,
    FN_SDIV = 2'd2,
    FN_SREM = 2'd3
  } func_t;

  // Word handed from cell to cell along the divider chain
  typedef struct packed {
    logic              valid;
    logic              rem_sel;  // deliver remainder instead of quotient
    logic              neg;      // negate the delivered value
    logic              zero;     // divisor was zero: deliver 0
    logic [DATA_W-1:0] part;     // partial remainder
    logic [DATA_W-1:0] qd;       // dividend bits out at the top, quotient bits in at the bottom
    logic [DATA_W-1:0] dvs;      // divisor magnitude
  } stage_t;

endpackage

`default_nettype wire

FILE: hdl/idm_prep.sv
`default_nettype none

module idm_prep
  import idm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic               req_valid,
  input  wire logic [FUNC_W-1:0]  func,
  input  wire logic [FIELD_W-1:0] dividend,
  input  wire logic [FIELD_W-1:0] divisor,
  output stage_t                  stage
);

  logic              sgn;
  logic              rem_sel;
  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic              a_neg;
  logic              b_neg;
  stage_t            stage_next;

  // Decode the request and take magnitudes of signed operands
  always_comb begin
    sgn     = (func_t'(func) == FN_SDIV) || (func_t'(func) == FN_SREM);
    rem_sel = (func_t'(func) == FN_UREM) || (func_t'(func) == FN_SREM);
    a       = dividend[DATA_W-1:0];
    b       = divisor[DATA_W-1:0];
    a_neg   = sgn && a[DATA_W-1];
    b_neg   = sgn && b[DATA_W-1];

    stage_next.valid   = req_valid;
    stage_next.rem_sel = rem_sel;
    stage_next.neg     = rem_sel ? a_neg : (a_neg ^ b_neg);
    stage_next.zero    = (b == '0);
    stage_next.part    = '0;
    stage_next.qd      = a_neg ? (~a + DATA_W'(1)) : a;
    stage_next.dvs     = b_neg ? (~b + DATA_W'(1)) : b;
  end

  // Register the request at the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (adv) begin
      stage <= stage_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/idm_cell.sv
`default_nettype none

module idm_cell
  import idm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  stage_t    prev,
  output stage_t    stage
);

  logic [DATA_W:0] shifted;
  logic [DATA_W:0] diff;
  logic            fits;
  stage_t          stage_next;

  // One restoring step: shift in the next dividend bit, subtract when the divisor fits
  always_comb begin
    shifted = {prev.part, prev.qd[DATA_W-1]};
    diff    = shifted - {1'b0, prev.dvs};
    fits    = !diff[DATA_W];

    stage_next      = prev;
    stage_next.part = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
    stage_next.qd   = {prev.qd[DATA_W-2:0], fits};
  end

  // Hand the step result to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (adv) begin
      stage <= stage_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/idm_post.sv
`default_nettype none

module idm_post
  import idm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 adv,
  input  stage_t                    last,
  output logic                      res_valid,
  output logic [M_TDATA_W-1:0]      result
);

  logic [DATA_W-1:0]    sel;
  logic [DATA_W-1:0]    signed_val;
  logic [M_TDATA_W-1:0] result_next;

  // Pick quotient or remainder, fix the sign, force zero on a zero divisor
  always_comb begin
    sel         = last.rem_sel ? last.part : last.qd;
    signed_val  = last.neg ? (~sel + DATA_W'(1)) : sel;
    result_next = last.zero ? '0 : M_TDATA_W'(signed_val);
  end

  // Hold the finished result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/int64_divide_modulo.sv
`default_nettype none

// Pipeline: an accepted request loads the entry register, then passes through
// one cell per quotient bit for 64 cells, then one output register.
// Throughput: one request per cycle; the whole chain advances together
// whenever the output register is empty or its result is taken.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
module int64_divide_modulo
  import idm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // [1:0] func, [65:2] dividend, [129:66] divisor, [135:130] zero
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [63:0] result
  output logic [M_TDATA_W-1:0]      m_tdata
);

  logic   adv;
  stage_t chain [DATA_W+1];

  // Advance the whole chain whenever the output register can take a new value
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  idm_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .req_valid (s_tvalid),
    .func      (s_tdata[FUNC_W-1:0]),
    .dividend  (s_tdata[FUNC_W +: FIELD_W]),
    .divisor   (s_tdata[FUNC_W+FIELD_W +: FIELD_W]),
    .stage     (chain[0])
  );

  // One cell per quotient bit
  for (genvar i = 0; i < DATA_W; i++) begin : g_cell
    idm_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .adv   (adv),
      .prev  (chain[i]),
      .stage (chain[i+1])
    );
  end

  idm_post u_post (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .last      (chain[DATA_W]),
    .res_valid (m_tvalid),
    .result    (m_tdata)
  );

`ifndef SYNTHESIS
  // An accepted request enters the chain on the next edge
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> chain[0].valid)
    else $error("accepted request did not enter the divider chain");

  // The final partial remainder is always below a nonzero divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    chain[DATA_W].valid && !chain[DATA_W].zero |-> chain[DATA_W].part < chain[DATA_W].dvs)
    else $error("remainder not reduced below divisor");

  // A zero divisor yields a zero result
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    adv && chain[DATA_W].valid && chain[DATA_W].zero |=> m_tvalid && (m_tdata == '0))
    else $error("zero divisor did not give zero");

  // Nothing is valid right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid && !chain[0].valid)
    else $error("valid state not cleared by reset");
`endif

endmodule

`default_nettype wire
